@@ design/fspa_pkg.sv @@
// Shared types and constants of the fixed-slot pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fspa_pkg;

  localparam int MAX_SLOTS     = 256;
  localparam int ADDR_BITS     = 32;
  localparam int SLOT_W        = $clog2(MAX_SLOTS);
  localparam int COUNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int SHIFT_W       = 5;
  localparam int ENTRY_W       = 9;
  localparam int ALIGN_LOG_MAX = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [ADDR_BITS-1:0] BASE_RESET  = '0;
  localparam logic [SHIFT_W-1:0]   SHIFT_RESET = 5'd3;
  localparam logic [ENTRY_W-1:0]   COUNT_RESET = 9'd256;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_SPACE      = 3'd1,
    ST_MISALIGNED    = 3'd2,
    ST_OUT_OF_RANGE  = 3'd3,
    ST_NOT_ALLOCATED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REJECT = 2'd2
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_POP  = 2'd1,
    BK_FREE = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [SHIFT_W-1:0]   shift;
    logic [COUNT_W-1:0]   limit;
    logic                 init;
  } pool_cfg_t;

  typedef struct packed {
    op_kind_t          kind;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              mismatch;
  } op_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] slot_address;
    logic [SLOT_W-1:0]    slot_index;
    logic                 offset_mismatch;
    logic [COUNT_W-1:0]   used_slots;
  } result_t;

endpackage

`default_nettype wire

@@ design/fspa_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ design/fspa_front.sv @@
// Front end: configuration registers and classification of incoming requests.
`timescale 1ns / 1ps
`default_nettype none

module fspa_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fspa_pkg::ADDR_BITS-1:0]   cfg_data,
  input  wire logic                             in_valid,
  input  wire logic                             in_cmd,
  input  wire logic [fspa_pkg::ADDR_BITS-1:0]   in_address,
  output logic                                  op_valid,
  output fspa_pkg::op_t                         op,
  output fspa_pkg::pool_cfg_t                   pool_cfg
);

  logic [fspa_pkg::ADDR_BITS-1:0] base_r, base_nxt;
  logic [fspa_pkg::SHIFT_W-1:0]   shift_r, shift_nxt;
  logic [fspa_pkg::ENTRY_W-1:0]   count_r, count_nxt;
  logic                           cfg_hit;

  logic [fspa_pkg::COUNT_W-1:0]   limit;
  logic [1:0]                     align_log;
  logic [2:0]                     align_mask;
  logic [fspa_pkg::ADDR_BITS-1:0] diff;
  logic [fspa_pkg::ADDR_BITS-1:0] slot_full;
  logic                           misaligned;
  logic                           below;
  logic                           over;

  assign cfg_ready = 1'b1;

  always_comb begin
    base_nxt  = base_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    cfg_hit   = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        fspa_pkg::CFG_BASE: begin
          base_nxt = cfg_data;
          cfg_hit  = 1'b1;
        end
        fspa_pkg::CFG_SIZE: begin
          shift_nxt = cfg_data[fspa_pkg::SHIFT_W-1:0];
          cfg_hit   = 1'b1;
        end
        fspa_pkg::CFG_COUNT: begin
          count_nxt = cfg_data[fspa_pkg::ENTRY_W-1:0];
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= fspa_pkg::BASE_RESET;
      shift_r <= fspa_pkg::SHIFT_RESET;
      count_r <= fspa_pkg::COUNT_RESET;
    end else begin
      base_r  <= base_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
    end
  end

  // Slot counts above the pool capacity are clamped to it.
  assign limit = (count_r > fspa_pkg::ENTRY_W'(fspa_pkg::MAX_SLOTS)) ?
                 fspa_pkg::COUNT_W'(fspa_pkg::MAX_SLOTS) : fspa_pkg::COUNT_W'(count_r);

  assign pool_cfg.base  = base_r;
  assign pool_cfg.shift = shift_r;
  assign pool_cfg.limit = limit;
  assign pool_cfg.init  = cfg_hit;

  // Alignment is checked against the smaller of eight bytes and the slot size.
  assign align_log  = (shift_r > fspa_pkg::SHIFT_W'(fspa_pkg::ALIGN_LOG_MAX)) ?
                      2'(fspa_pkg::ALIGN_LOG_MAX) : shift_r[1:0];
  assign align_mask = ~(3'b111 << align_log);
  assign misaligned = |(in_address[2:0] & align_mask);
  assign below      = in_address < base_r;
  assign diff       = in_address - base_r;
  assign slot_full  = diff >> shift_r;
  assign over       = slot_full >= fspa_pkg::ADDR_BITS'(limit);

  assign op_valid = in_valid;

  always_comb begin
    op.kind     = fspa_pkg::OP_REJECT;
    op.status   = fspa_pkg::ST_OK;
    op.slot     = slot_full[fspa_pkg::SLOT_W-1:0];
    op.mismatch = |(diff & ~({fspa_pkg::ADDR_BITS{1'b1}} << shift_r));
    if (in_cmd == fspa_pkg::CMD_ALLOC) begin
      op.kind = fspa_pkg::OP_ALLOC;
    end else begin
      priority if (misaligned) begin
        op.status = fspa_pkg::ST_MISALIGNED;
      end else if (below || over) begin
        op.status = fspa_pkg::ST_OUT_OF_RANGE;
      end else begin
        op.kind = fspa_pkg::OP_FREE;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/fspa_queue.sv @@
// Short request queue between the front end and the slot engine.
`timescale 1ns / 1ps
`default_nettype none

module fspa_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire fspa_pkg::op_t wr_op,
  output logic               rd_valid,
  input  wire logic          rd_pop,
  output fspa_pkg::op_t      rd_op
);

  localparam int PTR_W = $clog2(fspa_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(fspa_pkg::QUEUE_DEPTH + 1);

  fspa_pkg::op_t    slots_r [fspa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = cnt_r != CNT_W'(fspa_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_op    = slots_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(fspa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(fspa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

`default_nettype wire

@@ design/fspa_back.sv @@
// Slot engine: free stack, busy bits, counters and the result register.
`timescale 1ns / 1ps
`default_nettype none

module fspa_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fspa_pkg::pool_cfg_t pool_cfg,
  input  wire logic                q_valid,
  input  wire fspa_pkg::op_t       q_op,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fspa_pkg::result_t        out_res
);

  localparam int SW = fspa_pkg::SLOT_W;
  localparam int CW = fspa_pkg::COUNT_W;

  fspa_pkg::bk_state_t      state_r, state_nxt;
  logic [CW-1:0]            depth_r, depth_nxt;
  logic [CW-1:0]            fresh_r, fresh_nxt;
  logic [CW-1:0]            total_r, total_nxt;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic                     mis_r, mis_nxt;
  logic                     out_valid_r, out_valid_nxt;
  fspa_pkg::result_t        out_res_r;

  logic                     out_free;
  logic                     start;
  logic [CW-1:0]            depth_m1;
  logic                     stack_we;
  logic [SW-1:0]            stack_addr;
  logic [SW-1:0]            stack_wdata;
  logic [SW-1:0]            stack_rdata;
  logic                     busy_we;
  logic [SW-1:0]            busy_addr;
  logic                     busy_wdata;
  logic                     busy_rdata;
  logic                     slot_live;

  logic                     res_load;
  logic                     res_ok;
  fspa_pkg::status_t        res_status;
  logic [SW-1:0]            res_idx;
  logic                     res_mis;
  logic [fspa_pkg::ADDR_BITS-1:0] res_addr;

  assign out_free = !out_valid_r || out_ready;
  assign start    = (state_r == fspa_pkg::BK_IDLE) && q_valid && out_free;
  assign q_pop    = start;
  assign depth_m1 = depth_r - 1'b1;

  // Slots at or above the fresh counter were not handed out since the pool was
  // initialized, so whatever their busy bits still hold is ignored.
  assign slot_live = busy_rdata && ({1'b0, slot_r} < fresh_r);

  fspa_ram #(
    .WIDTH(SW),
    .DEPTH(fspa_pkg::MAX_SLOTS)
  ) u_stack (
    .clk  (clk),
    .we   (stack_we),
    .addr (stack_addr),
    .wdata(stack_wdata),
    .rdata(stack_rdata)
  );

  fspa_ram #(
    .WIDTH(1),
    .DEPTH(fspa_pkg::MAX_SLOTS)
  ) u_busy (
    .clk  (clk),
    .we   (busy_we),
    .addr (busy_addr),
    .wdata(busy_wdata),
    .rdata(busy_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fspa_pkg::BK_IDLE: begin
        if (start) begin
          if ((q_op.kind == fspa_pkg::OP_ALLOC) && (depth_r != '0)) begin
            state_nxt = fspa_pkg::BK_POP;
          end else if (q_op.kind == fspa_pkg::OP_FREE) begin
            state_nxt = fspa_pkg::BK_FREE;
          end
        end
      end
      fspa_pkg::BK_POP: begin
        state_nxt = fspa_pkg::BK_IDLE;
      end
      fspa_pkg::BK_FREE: begin
        state_nxt = fspa_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = fspa_pkg::BK_IDLE;
      end
    endcase
    if (pool_cfg.init) begin
      state_nxt = fspa_pkg::BK_IDLE;
    end
  end

  always_comb begin
    depth_nxt   = depth_r;
    fresh_nxt   = fresh_r;
    total_nxt   = total_r;
    slot_nxt    = slot_r;
    mis_nxt     = mis_r;
    stack_we    = 1'b0;
    stack_addr  = depth_r[SW-1:0];
    stack_wdata = slot_r;
    busy_we     = 1'b0;
    busy_addr   = slot_r;
    busy_wdata  = 1'b0;
    res_load    = 1'b0;
    res_ok      = 1'b0;
    res_status  = fspa_pkg::ST_OK;
    res_idx     = '0;
    res_mis     = 1'b0;
    unique case (state_r)
      fspa_pkg::BK_IDLE: begin
        if (start) begin
          unique case (q_op.kind)
            fspa_pkg::OP_ALLOC: begin
              if (depth_r != '0) begin
                // The popped index arrives from the stack RAM next cycle.
                stack_addr = depth_m1[SW-1:0];
                depth_nxt  = depth_m1;
              end else if (fresh_r < pool_cfg.limit) begin
                res_load   = 1'b1;
                res_ok     = 1'b1;
                res_idx    = fresh_r[SW-1:0];
                fresh_nxt  = fresh_r + 1'b1;
                total_nxt  = total_r + 1'b1;
                busy_we    = 1'b1;
                busy_addr  = fresh_r[SW-1:0];
                busy_wdata = 1'b1;
              end else begin
                res_load   = 1'b1;
                res_status = fspa_pkg::ST_NO_SPACE;
              end
            end
            fspa_pkg::OP_FREE: begin
              // The busy bit of the slot arrives from its RAM next cycle.
              busy_addr = q_op.slot;
              slot_nxt  = q_op.slot;
              mis_nxt   = q_op.mismatch;
            end
            default: begin
              res_load   = 1'b1;
              res_status = q_op.status;
            end
          endcase
        end
      end
      fspa_pkg::BK_POP: begin
        res_load   = 1'b1;
        res_ok     = 1'b1;
        res_idx    = stack_rdata;
        total_nxt  = total_r + 1'b1;
        busy_we    = 1'b1;
        busy_addr  = stack_rdata;
        busy_wdata = 1'b1;
      end
      fspa_pkg::BK_FREE: begin
        res_load = 1'b1;
        if (slot_live) begin
          res_ok    = 1'b1;
          res_idx   = slot_r;
          res_mis   = mis_r;
          busy_we   = 1'b1;
          total_nxt = total_r - 1'b1;
          stack_we  = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end else begin
          res_status = fspa_pkg::ST_NOT_ALLOCATED;
        end
      end
      default: begin
      end
    endcase
    if (pool_cfg.init) begin
      depth_nxt = '0;
      fresh_nxt = '0;
      total_nxt = '0;
    end
  end

  assign res_addr = res_ok ?
                    pool_cfg.base + (fspa_pkg::ADDR_BITS'(res_idx) << pool_cfg.shift) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fspa_pkg::BK_IDLE;
      depth_r     <= '0;
      fresh_r     <= '0;
      total_r     <= '0;
      slot_r      <= '0;
      mis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      fresh_r     <= fresh_nxt;
      total_r     <= total_nxt;
      slot_r      <= slot_nxt;
      mis_r       <= mis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r.status          <= res_status;
      out_res_r.slot_address    <= res_addr;
      out_res_r.slot_index      <= res_idx;
      out_res_r.offset_mismatch <= res_mis;
      out_res_r.used_slots      <= total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef NO_ASSERTIONS
  // Every slot handed out fresh is either busy or waiting on the stack.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fspa_pkg::BK_POP) |->
      (({1'b0, depth_r} + {1'b0, total_r}) == {1'b0, fresh_r}))
    else $error("busy slots plus stacked slots differ from slots handed out");

  // During a pop the slot in flight is counted in neither place yet.
  a_pop_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fspa_pkg::BK_POP) |->
      (({1'b0, depth_r} + {1'b0, total_r} + 1'b1) == {1'b0, fresh_r}))
    else $error("slot count off during stack pop");

  a_second_cycle_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fspa_pkg::BK_IDLE) |-> !out_valid_r)
    else $error("result register occupied while a two-cycle request completes");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= pool_cfg.limit)
    else $error("fresh slot counter beyond the pool size");
`endif

endmodule

`default_nettype wire

@@ design/fixed_slot_pool_allocator_top.sv @@
// Top level of the fixed-slot pool allocator.
// Flow: a request beat enters the queue; fresh allocations and rejects load the result
// register from IDLE, while frees and allocations that reuse a freed slot pass through
// BK_FREE or BK_POP, waiting on a synchronous read of the busy bits or the free stack.
// The back takes no new request until it returns to IDLE. A held result stalls the back.
// Reset: synchronous, active low; clears counters and the queue, not the RAMs, so requests
// are accepted right after reset (busy bits count only below the fresh-slot counter).
`timescale 1ns / 1ps
`default_nettype none

module fixed_slot_pool_allocator_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fspa_pkg::ADDR_BITS-1:0] cfg_data,
  // Request stream.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [31:0]                    in_tdata,  // address[31:0]
  input  wire logic                           in_tuser,  // cmd[0]
  // Result stream.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // slot_address[31:0], slot_index[39:32], offset_mismatch[40], used_slots[49:41],
  // zero [55:50]
  output logic [55:0]                         out_tdata,
  output logic [2:0]                          out_tuser  // status[2:0]
);

  fspa_pkg::pool_cfg_t pool_cfg;
  fspa_pkg::op_t       front_op;
  fspa_pkg::op_t       q_op;
  fspa_pkg::result_t   res;
  logic                front_valid;
  logic                q_valid;
  logic                q_pop;

  fspa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_address(in_tdata),
    .op_valid  (front_valid),
    .op        (front_op),
    .pool_cfg  (pool_cfg)
  );

  fspa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(front_valid),
    .wr_ready(in_tready),
    .wr_op   (front_op),
    .rd_valid(q_valid),
    .rd_pop  (q_pop),
    .rd_op   (q_op)
  );

  fspa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pool_cfg (pool_cfg),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {6'b0, res.used_slots, res.offset_mismatch, res.slot_index,
                      res.slot_address};

endmodule

`default_nettype wire
